/* src/assert_macros.svh */
// Assertion macros shared by the boot frame command decoder RTL.
// Depends on nothing; the modules that include it provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define BFCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen outside reset.
`define BFCD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BFCD_ASSERT(lbl, prop, msg)
`define BFCD_NEVER(lbl, cond, msg)
`endif
`endif

/* src/bfcd_pkg.sv */
// Shared types and constants of the boot frame command decoder.
// Used by bfcd_frame_acc, bfcd_cmd_dec and the top level; no dependencies.
package bfcd_pkg;

  localparam int FRAME_BYTES = 10;
  localparam int WRITE_BYTES = 8;
  localparam int POS_W       = 4;

  localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_BYTES - 1);
  localparam logic [31:0]      BASE_RESET  = 32'h0050_0000;
  localparam logic [31:0]      OFFSET_STEP = 32'(WRITE_BYTES);
  localparam logic [8:0]       CHK_MOD     = 9'd255;

  typedef logic [7:0] frame_word_t [FRAME_BYTES];

  localparam frame_word_t WAKE_WORD = '{"!", "O", "T", "T", "O", "W", "A", "K", "E", "!"};
  localparam frame_word_t JUMP_WORD = '{"!", "O", "T", "T", "O", "J", "U", "M", "P", "!"};
  localparam frame_word_t SKIP_WORD = '{"!", "S", "K", "I", "P", "J", "U", "M", "P", "!"};

  typedef enum logic [2:0] {
    ACT_IGNORE = 3'd0,
    ACT_BOOT   = 3'd1,
    ACT_DATA   = 3'd2,
    ACT_FILL   = 3'd3,
    ACT_JUMP   = 3'd4
  } action_t;

  // Summary of a frame whose last byte is being taken in this cycle.
  typedef struct packed {
    logic        done;
    logic        wake;
    logic        jump;
    logic        skip;
    logic        sum_ok;
    logic        nonzero;
    logic [63:0] payload;
  } frame_sum_t;

endpackage

/* src/bfcd_frame_acc.sv */
// Frame accumulator: byte position, checksum, payload and word match flags.
// Depends on bfcd_pkg.
module bfcd_frame_acc
  import bfcd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_vld,
  input  logic [7:0]       rx_byte,
  output logic             at_last,
  output frame_sum_t       frame_sum
);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic [7:0]       chk_r, chk_nxt;
  logic [63:0]      payload_r, payload_nxt, payload_now;
  logic [2:0]       flags_r, flags_nxt, flags_now;
  logic             nz_r, nz_nxt, nz_now;
  logic [8:0]       sum_ext;

  always_comb begin
    pos_eff   = (pos_r > LAST_POS) ? '0 : pos_r;
    at_last   = (pos_eff == LAST_POS);
    flags_now = flags_r & {rx_byte == SKIP_WORD[pos_eff],
                           rx_byte == JUMP_WORD[pos_eff],
                           rx_byte == WAKE_WORD[pos_eff]};
    nz_now    = nz_r | (rx_byte != 8'd0);
    sum_ext   = {1'b0, chk_r} + {1'b0, rx_byte};
    if (sum_ext >= CHK_MOD) begin
      sum_ext = sum_ext - CHK_MOD;
    end
    payload_now = payload_r;
    for (int k = 0; k < WRITE_BYTES; k++) begin
      if (pos_eff == POS_W'(k + 1)) begin
        payload_now[k*8 +: 8] = rx_byte;
      end
    end

    pos_nxt     = pos_r;
    chk_nxt     = chk_r;
    payload_nxt = payload_r;
    flags_nxt   = flags_r;
    nz_nxt      = nz_r;
    if (byte_vld) begin
      if (at_last) begin
        pos_nxt     = '0;
        chk_nxt     = '0;
        payload_nxt = '0;
        flags_nxt   = '1;
        nz_nxt      = 1'b0;
      end else begin
        pos_nxt     = pos_eff + POS_W'(1);
        chk_nxt     = sum_ext[7:0];
        payload_nxt = payload_now;
        flags_nxt   = flags_now;
        nz_nxt      = nz_now;
      end
    end

    frame_sum.done    = byte_vld & at_last;
    frame_sum.wake    = flags_now[0];
    frame_sum.jump    = flags_now[1];
    frame_sum.skip    = flags_now[2];
    frame_sum.sum_ok  = (rx_byte == chk_r);
    frame_sum.nonzero = nz_now;
    frame_sum.payload = payload_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      chk_r   <= '0;
      flags_r <= '1;
      nz_r    <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      chk_r   <= chk_nxt;
      flags_r <= flags_nxt;
      nz_r    <= nz_nxt;
    end
  end

  // Every payload lane is rewritten before the frame's last byte.
  always_ff @(posedge clk) begin
    payload_r <= payload_nxt;
  end

endmodule

/* src/bfcd_cmd_dec.sv */
// Command decoder: boot mode, write offset, base register and result register.
// Depends on bfcd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bfcd_cmd_dec
  import bfcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  frame_sum_t  frame_sum,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [31:0] out_write_address,
  output logic [63:0] out_write_data
);

  logic        boot_r, boot_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [31:0] base_r;
  logic        valid_r, valid_nxt;
  action_t     action_r, action_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [63:0] data_r, data_nxt;

  always_comb begin
    boot_nxt   = boot_r;
    offset_nxt = offset_r;
    action_nxt = ACT_IGNORE;
    addr_nxt   = '0;
    data_nxt   = '0;
    if (frame_sum.done && frame_sum.nonzero) begin
      if (boot_r) begin
        if (frame_sum.jump) begin
          boot_nxt   = 1'b0;
          action_nxt = ACT_JUMP;
        end else if (frame_sum.sum_ok) begin
          action_nxt = ACT_DATA;
          addr_nxt   = base_r + offset_r;
          data_nxt   = frame_sum.payload;
          offset_nxt = offset_r + OFFSET_STEP;
        end else if (frame_sum.skip) begin
          action_nxt = ACT_FILL;
          addr_nxt   = base_r + offset_r;
          offset_nxt = offset_r + OFFSET_STEP;
        end
      end else if (frame_sum.wake) begin
        boot_nxt   = 1'b1;
        action_nxt = ACT_BOOT;
      end
    end

    if (frame_sum.done) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_r   <= 1'b0;
      offset_r <= '0;
      base_r   <= BASE_RESET;
      valid_r  <= 1'b0;
    end else begin
      boot_r   <= boot_nxt;
      offset_r <= offset_nxt;
      valid_r  <= valid_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
    end
  end

  // The frame stage only completes a frame when the result register is free.
  always_ff @(posedge clk) begin
    if (frame_sum.done) begin
      action_r <= action_nxt;
      addr_r   <= addr_nxt;
      data_r   <= data_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_action        = action_r;
  assign out_write_address = addr_r;
  assign out_write_data    = data_r;

  `BFCD_ASSERT(a_done_gives_result, frame_sum.done |=> valid_r, "completed frame lost")
  `BFCD_ASSERT(a_offset_only_on_frame, !frame_sum.done |=> $stable(offset_r), "offset moved")
  `BFCD_ASSERT(a_boot_entry_reported, $rose(boot_r) |-> valid_r && action_r == ACT_BOOT, "boot entry")
  `BFCD_NEVER(a_data_only_on_write, valid_r && action_r != ACT_DATA && data_r != 64'd0, "data")
  `BFCD_NEVER(a_addr_only_on_write, valid_r && action_r != ACT_DATA && action_r != ACT_FILL && addr_r != 32'd0, "addr")

endmodule

/* src/boot_frame_command_decoder_unit.sv */
// Boot frame command decoder: an accepted last byte of a frame reaches its result
// through the input register, then frame decode into the result register.
// Throughput is one byte per cycle unless the input stalls; every tenth byte closes
// a frame and yields one result transaction. The input stage stalls only when a frame's
// last byte meets a result that is still stalled downstream. Synchronous active-low
// reset returns to idle mode, offset 0, frame start, and base address 0x0050_0000.
module boot_frame_command_decoder_unit
  import bfcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [31:0] out_write_address,
  output logic [63:0] out_write_data
);

  // Input register: holds one accepted byte until the frame logic takes it.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_adv;
  logic       at_last;
  frame_sum_t frame_sum;

  // A byte that closes a frame can only move on if the result register
  // is empty or is being emptied by a completing output transaction.
  assign s1_adv       = !(s1_valid_r && at_last && out_valid && out_stall);
  assign in_stall     = s1_valid_r && !s1_adv;
  assign s1_valid_nxt = s1_adv ? in_valid : s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Per-byte state: position, checksum, payload lanes and word match flags.
  bfcd_frame_acc u_frame_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_vld  (s1_valid_r && s1_adv),
    .rx_byte   (s1_byte_r),
    .at_last   (at_last),
    .frame_sum (frame_sum)
  );

  // Per-frame decision and the result register.
  bfcd_cmd_dec u_cmd_dec (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .frame_sum         (frame_sum),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data)
  );

endmodule

/* tb/tb_boot_frame_command_decoder_unit.sv */
// Self-checking testbench for boot_frame_command_decoder_unit: drives byte streams
// of wake, jump, skip, data and malformed frames and checks every decoded result.
// Depends on bfcd_pkg and the top level of the block; needs nothing else.
module tb_boot_frame_command_decoder_unit;
  import bfcd_pkg::*;

  // The run ends with a failure if it has not finished after this many cycles.
  localparam int unsigned CYCLE_LIMIT      = 400000;
  // Cycles to let pass after the last expected result has been taken.
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned FRAMES_PER_PHASE = 26;
  localparam int unsigned HOLD_CYCLES      = 300;
  localparam int unsigned MAX_REPORTS      = 10;

  // Kinds of frames that the stimulus generator can build.
  typedef enum int unsigned {
    FK_WAKE,
    FK_JUMP,
    FK_SKIP,
    FK_DATA,
    FK_BAD_SUM,
    FK_ZERO,
    FK_NEAR,
    FK_RANDOM
  } frame_kind_t;

  // Patterns that the result side uses to stall the block.
  typedef enum int unsigned {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  // One decoded frame as it should leave the block.
  typedef struct {
    action_t     action;
    logic [31:0] address;
    logic [63:0] data;
  } flash_write_t;

  // Tracks the decoder state from the accepted bytes, queues the result that each
  // completed frame must produce and compares the result transactions against it.
  class boot_write_tracker;
    logic [31:0]  base_address;
    bit           boot_mode;
    int unsigned  position;
    logic [7:0]   checksum;
    logic [63:0]  payload;
    bit           wake_hit;
    bit           jump_hit;
    bit           skip_hit;
    bit           nonzero;
    logic [31:0]  offset;
    flash_write_t pending_writes[$];
    int unsigned  mismatch_count;

    function new();
      base_address   = BASE_RESET;
      boot_mode      = 1'b0;
      offset         = '0;
      mismatch_count = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      position = 0;
      checksum = '0;
      payload  = '0;
      wake_hit = 1'b1;
      jump_hit = 1'b1;
      skip_hit = 1'b1;
      nonzero  = 1'b0;
    endfunction

    // Takes one accepted byte; the tenth byte of a frame queues one result.
    function void take_byte(logic [7:0] rx);
      logic [8:0]   sum;
      flash_write_t wr;
      if (rx != WAKE_WORD[position]) wake_hit = 1'b0;
      if (rx != JUMP_WORD[position]) jump_hit = 1'b0;
      if (rx != SKIP_WORD[position]) skip_hit = 1'b0;
      if (rx != 8'h00) nonzero = 1'b1;
      if (position >= 1 && position <= WRITE_BYTES) payload[(position-1)*8 +: 8] = rx;
      if (position < FRAME_BYTES - 1) begin
        sum = {1'b0, checksum} + {1'b0, rx};
        if (sum >= 9'd255) sum = sum - 9'd255;
        checksum = sum[7:0];
        position++;
        return;
      end
      wr.action  = ACT_IGNORE;
      wr.address = '0;
      wr.data    = '0;
      if (nonzero) begin
        if (boot_mode) begin
          // The jump word wins over a matching checksum, which wins over the skip word.
          if (jump_hit) begin
            boot_mode = 1'b0;
            wr.action = ACT_JUMP;
          end else if (rx == checksum) begin
            wr.action  = ACT_DATA;
            wr.address = base_address + offset;
            wr.data    = payload;
            offset     = offset + 32'(WRITE_BYTES);
          end else if (skip_hit) begin
            wr.action  = ACT_FILL;
            wr.address = base_address + offset;
            offset     = offset + 32'(WRITE_BYTES);
          end
        end else if (wake_hit) begin
          boot_mode = 1'b1;
          wr.action = ACT_BOOT;
        end
      end
      pending_writes.push_back(wr);
      restart_frame();
    endfunction

    // Compares one result transaction with the oldest queued expectation.
    function void match_write(logic [2:0] action, logic [31:0] address, logic [63:0] data);
      flash_write_t wr;
      if (pending_writes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: action %0d address %h data %h",
                   action, address, data);
        return;
      end
      wr = pending_writes.pop_front();
      if (action !== wr.action || address !== wr.address || data !== wr.data) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display({"mismatch: expected action %0d address %h data %h, ",
                    "got action %0d address %h data %h"},
                   wr.action, wr.address, wr.data, action, address, data);
      end
    endfunction
  endclass

  // All block inputs start at known values; reset is held low from time zero.
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte  = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [2:0]  out_action;
  logic [31:0] out_write_address;
  logic [63:0] out_write_data;

  boot_write_tracker tracker = new();

  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;
  bit          hold_req    = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned mode_left   = 0;
  int unsigned rx_tick     = 0;
  rx_mode_t    rx_mode     = RX_FREE;

  boot_frame_command_decoder_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_action        (out_action),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Monitor. Both channels are sampled at the rising edge, so the values seen are
  // the ones that were stable across the edge. An accepted input transaction feeds
  // the tracker, and an accepted result transaction is checked against it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.take_byte(in_rx_byte);
      if (out_valid && !out_stall)
        tracker.match_write(out_action, out_write_address, out_write_data);
    end
  end

  // Result side. It switches between stall patterns at random intervals, with
  // stretches of no stall at all. When the stimulus raises hold_req, it stalls for a
  // long stretch that it counts itself, so the block fills and stalls its input.
  always @(negedge clk) begin
    rx_tick++;
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_FREE:     out_stall <= 1'b0;
        RX_LIGHT:    out_stall <= ($urandom_range(0, 99) < 25);
        RX_HEAVY:    out_stall <= ($urandom_range(0, 99) < 75);
        default:     out_stall <= (rx_tick % 3 != 0);
      endcase
    end
  end

  // Offers one byte at a falling edge and returns once it was accepted and any gap
  // that follows it has passed. Bursts of random length are separated by random gaps,
  // so gaps land on every position within a frame; some bursts run without a gap.
  task automatic send_byte(input logic [7:0] rx);
    int unsigned gap;
    in_valid   <= 1'b1;
    in_rx_byte <= rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_frame(input frame_word_t frame);
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  // Stops offering bytes and waits until every expected result has been taken,
  // then lets the drain period pass so that no frame is still inside the block.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes the base address register; called only while the block is idle.
  task automatic write_base(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    tracker.base_address = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Builds a frame of the given kind. Data frames carry the correct checksum in the
  // last byte; bad-sum frames carry a wrong one, often 0xFF, which never matches.
  // Near frames are one of the three command words with a single bit flipped.
  function automatic frame_word_t build_frame(frame_kind_t kind);
    frame_word_t frame;
    logic [8:0]  sum;
    int unsigned pick;
    case (kind)
      FK_WAKE: frame = WAKE_WORD;
      FK_JUMP: frame = JUMP_WORD;
      FK_SKIP: frame = SKIP_WORD;
      FK_ZERO: foreach (frame[i]) frame[i] = 8'h00;
      FK_RANDOM: foreach (frame[i]) frame[i] = 8'($urandom_range(0, 255));
      FK_NEAR: begin
        pick = $urandom_range(0, 2);
        case (pick)
          0:       frame = WAKE_WORD;
          1:       frame = JUMP_WORD;
          default: frame = SKIP_WORD;
        endcase
        pick = $urandom_range(0, FRAME_BYTES - 1);
        frame[pick] = frame[pick] ^ (8'h01 << $urandom_range(0, 7));
      end
      default: begin
        sum = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
          pick = $urandom_range(0, 9);
          frame[i] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
          sum = sum + {1'b0, frame[i]};
          if (sum >= 9'd255) sum = sum - 9'd255;
        end
        frame[FRAME_BYTES-1] = sum[7:0];
        if (kind == FK_BAD_SUM)
          frame[FRAME_BYTES-1] = $urandom_range(0, 1) ? 8'hFF
                                                      : sum[7:0] + 8'($urandom_range(1, 255));
      end
    endcase
    return frame;
  endfunction

  initial begin
    frame_word_t frame;
    logic [31:0] bases [6];
    int unsigned roll;
    frame_kind_t kind;

    bases[0] = 32'h0000_0000;
    bases[1] = 32'hFFFF_FFFF;
    bases[2] = 32'hFFFF_FFF0;
    bases[3] = $urandom;
    bases[4] = $urandom;
    bases[5] = BASE_RESET;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, at the reset base address. In idle mode an all-zero frame,
    // the jump word and a valid data frame must all be ignored.
    send_frame(build_frame(FK_ZERO));
    send_frame(JUMP_WORD);
    send_frame(build_frame(FK_DATA));
    send_frame(WAKE_WORD);
    // In boot mode an all-zero frame is still ignored.
    send_frame(build_frame(FK_ZERO));
    // Every byte at 0xFF sums to zero mod 255, so this is a data frame of all ones.
    foreach (frame[i]) frame[i] = 8'hFF;
    frame[FRAME_BYTES-1] = 8'h00;
    send_frame(frame);
    // A nonzero frame whose payload is all zeros is a data write of zeros.
    foreach (frame[i]) frame[i] = 8'h00;
    frame[0] = 8'h01;
    frame[FRAME_BYTES-1] = 8'h01;
    send_frame(frame);
    // A checksum byte of 0xFF can never match, so this frame is ignored.
    frame = build_frame(FK_DATA);
    frame[FRAME_BYTES-1] = 8'hFF;
    send_frame(frame);
    send_frame(SKIP_WORD);
    // The wake word has no special meaning once in boot mode.
    send_frame(WAKE_WORD);
    // The jump leaves boot mode but keeps the write offset for the next session.
    send_frame(JUMP_WORD);
    send_frame(WAKE_WORD);
    send_frame(build_frame(FK_DATA));

    // Random part: one phase per base address setting, each written while idle.
    // Most frames are well formed so that the decoder spends its time in boot mode;
    // the rest are near misses, bad checksums, zero frames and random bytes.
    foreach (bases[p]) begin
      wait_idle();
      write_base(bases[p]);
      for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
        if (p == 1 && n == 4) hold_req = 1'b1;
        roll = $urandom_range(0, 99);
        if (!tracker.boot_mode) begin
          if (roll < 60)      kind = FK_WAKE;
          else if (roll < 70) kind = FK_DATA;
          else if (roll < 78) kind = FK_ZERO;
          else if (roll < 88) kind = FK_NEAR;
          else if (roll < 93) kind = FK_JUMP;
          else                kind = FK_RANDOM;
        end else begin
          if (roll < 45)      kind = FK_DATA;
          else if (roll < 60) kind = FK_SKIP;
          else if (roll < 70) kind = FK_BAD_SUM;
          else if (roll < 76) kind = FK_JUMP;
          else if (roll < 80) kind = FK_WAKE;
          else if (roll < 85) kind = FK_ZERO;
          else if (roll < 93) kind = FK_NEAR;
          else                kind = FK_RANDOM;
        end
        send_frame(build_frame(kind));
      end
    end

    wait_idle();
    if (tracker.mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
